// ===== rtl/core/bpv_pkg.sv =====
// shared types, constants and control point tables for the bezier patch evaluator
package bpv_pkg;

  localparam int NUM_PATCHES        = 10;
  localparam int NUM_CONTROL_POINTS = 127;
  localparam int PATCH_W            = 4;
  localparam int CP_IDX_W           = 7;

  localparam logic [15:0]        PARAM_ONE  = 16'd32768;
  localparam logic [63:0]        LEN_THRESH = 64'd42949673;
  localparam logic signed [15:0] UNIT_Q14   = 16'sd16384;
  localparam logic [15:0]        SCALE_RESET = 16'd4096;

  // configuration register indexes
  localparam logic [3:0] REG_SCALE_FACTOR = 4'd0;
  localparam logic [3:0] REG_FRAME_MODE   = 4'd1;

  typedef logic signed [31:0] comp_t;
  typedef logic signed [15:0] unit_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BAS1, S_BAS2, S_ACC, S_RND,
    S_NB_GO, S_NB_WAIT, S_NT_GO, S_NT_WAIT, S_CROSS,
    S_NN_GO, S_NN_WAIT, S_SCALE, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SQ, N_SQRT, N_LOAD, N_DIV, N_DONE
  } norm_state_t;

  localparam logic [CP_IDX_W-1:0] PATCH_ROM [NUM_PATCHES][16] = '{
    '{7'd102,7'd103,7'd104,7'd105,7'd4,7'd5,7'd6,7'd7,
      7'd8,7'd9,7'd10,7'd11,7'd12,7'd13,7'd14,7'd15},
    '{7'd12,7'd13,7'd14,7'd15,7'd16,7'd17,7'd18,7'd19,
      7'd20,7'd21,7'd22,7'd23,7'd24,7'd25,7'd26,7'd27},
    '{7'd24,7'd25,7'd26,7'd27,7'd29,7'd30,7'd31,7'd32,
      7'd33,7'd34,7'd35,7'd36,7'd37,7'd38,7'd39,7'd40},
    '{7'd96,7'd96,7'd96,7'd96,7'd97,7'd98,7'd99,7'd100,
      7'd101,7'd101,7'd101,7'd101,7'd0,7'd1,7'd2,7'd3},
    '{7'd0,7'd1,7'd2,7'd3,7'd106,7'd107,7'd108,7'd109,
      7'd110,7'd111,7'd112,7'd113,7'd114,7'd115,7'd116,7'd117},
    '{7'd41,7'd42,7'd43,7'd44,7'd45,7'd46,7'd47,7'd48,
      7'd49,7'd50,7'd51,7'd52,7'd53,7'd54,7'd55,7'd56},
    '{7'd53,7'd54,7'd55,7'd56,7'd57,7'd58,7'd59,7'd60,
      7'd61,7'd62,7'd63,7'd64,7'd28,7'd65,7'd66,7'd67},
    '{7'd68,7'd69,7'd70,7'd71,7'd72,7'd73,7'd74,7'd75,
      7'd76,7'd77,7'd78,7'd79,7'd80,7'd81,7'd82,7'd83},
    '{7'd80,7'd81,7'd82,7'd83,7'd84,7'd85,7'd86,7'd87,
      7'd88,7'd89,7'd90,7'd91,7'd92,7'd93,7'd94,7'd95},
    '{7'd118,7'd118,7'd118,7'd118,7'd124,7'd122,7'd119,7'd121,
      7'd123,7'd126,7'd125,7'd120,7'd40,7'd39,7'd38,7'd37}
  };

  localparam logic signed [15:0] CP_ROM [NUM_CONTROL_POINTS][3] = '{
    '{16'sd819,16'sd0,16'sd11059},'{16'sd819,-16'sd459,16'sd11059},
    '{16'sd459,-16'sd819,16'sd11059},'{16'sd0,-16'sd819,16'sd11059},
    '{16'sd5478,16'sd0,16'sd10368},'{16'sd5478,-16'sd3068,16'sd10368},
    '{16'sd3068,-16'sd5478,16'sd10368},'{16'sd0,-16'sd5478,16'sd10368},
    '{16'sd5888,16'sd0,16'sd10368},'{16'sd5888,-16'sd3297,16'sd10368},
    '{16'sd3297,-16'sd5888,16'sd10368},'{16'sd0,-16'sd5888,16'sd10368},
    '{16'sd6144,16'sd0,16'sd9830},'{16'sd6144,-16'sd3441,16'sd9830},
    '{16'sd3441,-16'sd6144,16'sd9830},'{16'sd0,-16'sd6144,16'sd9830},
    '{16'sd7168,16'sd0,16'sd7680},'{16'sd7168,-16'sd4014,16'sd7680},
    '{16'sd4014,-16'sd7168,16'sd7680},'{16'sd0,-16'sd7168,16'sd7680},
    '{16'sd8192,16'sd0,16'sd5530},'{16'sd8192,-16'sd4588,16'sd5530},
    '{16'sd4588,-16'sd8192,16'sd5530},'{16'sd0,-16'sd8192,16'sd5530},
    '{16'sd8192,16'sd0,16'sd3686},'{16'sd8192,-16'sd4588,16'sd3686},
    '{16'sd4588,-16'sd8192,16'sd3686},'{16'sd0,-16'sd8192,16'sd3686},
    '{-16'sd8192,16'sd0,16'sd3686},'{16'sd8192,16'sd0,16'sd1843},
    '{16'sd8192,-16'sd4588,16'sd1843},'{16'sd4588,-16'sd8192,16'sd1843},
    '{16'sd0,-16'sd8192,16'sd1843},'{16'sd6144,16'sd0,16'sd922},
    '{16'sd6144,-16'sd3441,16'sd922},'{16'sd3441,-16'sd6144,16'sd922},
    '{16'sd0,-16'sd6144,16'sd922},'{16'sd6144,16'sd0,16'sd614},
    '{16'sd6144,-16'sd3441,16'sd614},'{16'sd3441,-16'sd6144,16'sd614},
    '{16'sd0,-16'sd6144,16'sd614},'{-16'sd6554,16'sd0,16'sd8294},
    '{-16'sd6554,-16'sd1229,16'sd8294},'{-16'sd6144,-16'sd1229,16'sd9216},
    '{-16'sd6144,16'sd0,16'sd9216},'{-16'sd9421,16'sd0,16'sd8294},
    '{-16'sd9421,-16'sd1229,16'sd8294},'{-16'sd10240,-16'sd1229,16'sd9216},
    '{-16'sd10240,16'sd0,16'sd9216},'{-16'sd11059,16'sd0,16'sd8294},
    '{-16'sd11059,-16'sd1229,16'sd8294},'{-16'sd12288,-16'sd1229,16'sd9216},
    '{-16'sd12288,16'sd0,16'sd9216},'{-16'sd11059,16'sd0,16'sd7373},
    '{-16'sd11059,-16'sd1229,16'sd7373},'{-16'sd12288,-16'sd1229,16'sd7373},
    '{-16'sd12288,16'sd0,16'sd7373},'{-16'sd11059,16'sd0,16'sd6451},
    '{-16'sd11059,-16'sd1229,16'sd6451},'{-16'sd12288,-16'sd1229,16'sd5530},
    '{-16'sd12288,16'sd0,16'sd5530},'{-16'sd10240,16'sd0,16'sd4608},
    '{-16'sd10240,-16'sd1229,16'sd4608},'{-16'sd10854,-16'sd1229,16'sd3840},
    '{-16'sd10854,16'sd0,16'sd3840},'{-16'sd8192,-16'sd1229,16'sd3686},
    '{-16'sd7782,-16'sd1229,16'sd2458},'{-16'sd7782,16'sd0,16'sd2458},
    '{16'sd6963,16'sd0,16'sd5837},'{16'sd6963,-16'sd2703,16'sd5837},
    '{16'sd6963,-16'sd2703,16'sd2458},'{16'sd6963,16'sd0,16'sd2458},
    '{16'sd10650,16'sd0,16'sd5837},'{16'sd10650,-16'sd2703,16'sd5837},
    '{16'sd12698,-16'sd2703,16'sd3379},'{16'sd12698,16'sd0,16'sd3379},
    '{16'sd9421,16'sd0,16'sd8602},'{16'sd9421,-16'sd1024,16'sd8602},
    '{16'sd9830,-16'sd1024,16'sd8294},'{16'sd9830,16'sd0,16'sd8294},
    '{16'sd11059,16'sd0,16'sd9830},'{16'sd11059,-16'sd1024,16'sd9830},
    '{16'sd13517,-16'sd1024,16'sd9830},'{16'sd13517,16'sd0,16'sd9830},
    '{16'sd11469,16'sd0,16'sd10138},'{16'sd11469,-16'sd1024,16'sd10138},
    '{16'sd14438,-16'sd1024,16'sd10214},'{16'sd14438,16'sd0,16'sd10214},
    '{16'sd11878,16'sd0,16'sd10138},'{16'sd11878,-16'sd614,16'sd10138},
    '{16'sd14131,-16'sd614,16'sd10291},'{16'sd14131,16'sd0,16'sd10291},
    '{16'sd11469,16'sd0,16'sd9830},'{16'sd11469,-16'sd614,16'sd9830},
    '{16'sd13107,-16'sd614,16'sd9830},'{16'sd13107,16'sd0,16'sd9830},
    '{16'sd0,16'sd0,16'sd12902},'{16'sd3277,16'sd0,16'sd12902},
    '{16'sd3277,-16'sd1843,16'sd12902},'{16'sd1843,-16'sd3277,16'sd12902},
    '{16'sd0,-16'sd3277,16'sd12902},'{16'sd0,16'sd0,16'sd11674},
    '{16'sd5734,16'sd0,16'sd9830},'{16'sd5734,-16'sd3211,16'sd9830},
    '{16'sd3211,-16'sd5734,16'sd9830},'{16'sd0,-16'sd5734,16'sd9830},
    '{16'sd1638,16'sd0,16'sd10445},'{16'sd1638,-16'sd918,16'sd10445},
    '{16'sd918,-16'sd1638,16'sd10445},'{16'sd0,-16'sd1638,16'sd10445},
    '{16'sd5325,16'sd0,16'sd10445},'{16'sd5325,-16'sd2982,16'sd10445},
    '{16'sd2982,-16'sd5325,16'sd10445},'{16'sd0,-16'sd5325,16'sd10445},
    '{16'sd5325,16'sd0,16'sd9830},'{16'sd5325,-16'sd2982,16'sd9830},
    '{16'sd2982,-16'sd5325,16'sd9830},'{16'sd0,-16'sd5325,16'sd9830},
    '{16'sd0,16'sd0,16'sd0},'{16'sd5837,-16'sd3269,16'sd0},
    '{16'sd6144,16'sd0,16'sd307},'{16'sd5837,16'sd0,16'sd0},
    '{16'sd3269,-16'sd5837,16'sd0},'{16'sd0,-16'sd6144,16'sd307},
    '{16'sd0,-16'sd5837,16'sd0},'{16'sd6144,-16'sd3441,16'sd307},
    '{16'sd3441,-16'sd6144,16'sd307}
  };

endpackage

// ===== rtl/core/bezier_patch_vertex_eval.sv =====
// top level: bicubic bezier patch position and frame evaluator
//
// Input channel (in_valid/in_ready) carries patch_index, u_param, v_param.
// Output channel (out_valid/out_ready) carries the scaled position and the
// normal, tangent and binormal unit vectors of one vertex per input item.
// Config channel (cfg_valid/cfg_ready) writes scale_factor (index 0) and
// frame_mode (index 1); other indexes are dropped. cfg_ready is always high.
// One item is worked at a time: S_BAS1 and S_BAS2 build the u and then the v
// basis values, S_ACC accumulates the sixteen control points through shared
// multiply-accumulate lanes, then the normalizer runs three times (binormal,
// tangent, normal), each run a bit-serial 32-step square root and a 47-step
// divide for each component of a vector whose length is not zero.
// The finished result sits in an output register, so the next item is
// accepted while it waits; a stalled receiver holds the block in its last
// step only once a second result is ready. Reset clears the control state,
// sets scale_factor to 1.0 and frame_mode to 0.
module bezier_patch_vertex_eval
  import bpv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PATCH_W-1:0]  patch_index,
  input  logic [15:0]         u_param,
  input  logic [15:0]         v_param,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [23:0]  pos_x,
  output logic signed [23:0]  pos_y,
  output logic signed [23:0]  pos_z,
  output logic signed [15:0]  normal_x,
  output logic signed [15:0]  normal_y,
  output logic signed [15:0]  normal_z,
  output logic signed [15:0]  tangent_x,
  output logic signed [15:0]  tangent_y,
  output logic signed [15:0]  tangent_z,
  output logic signed [15:0]  binormal_x,
  output logic signed [15:0]  binormal_y,
  output logic signed [15:0]  binormal_z,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  state_t state, state_next;

  logic [15:0]        scale_factor;
  logic               frame_mode;

  logic [PATCH_W-1:0] pi_r;
  logic [15:0]        u_r, v_r;
  logic               bas_v;
  logic [31:0]        ww, tw, tt;
  logic signed [33:0] bu [4];
  logic signed [33:0] du [4];
  logic signed [33:0] bv [4];
  logic signed [33:0] dv [4];
  logic [4:0]         cnt;
  logic               mac_vld;
  logic signed [35:0] wp, wt, wb;
  logic signed [15:0] q_r [3];
  logic signed [55:0] ap [3];
  logic signed [55:0] at [3];
  logic signed [55:0] ab [3];
  comp_t              p [3];
  comp_t              t [3];
  comp_t              b [3];
  unit_t              bn [3];
  unit_t              tn [3];
  unit_t              nn [3];
  comp_t              nr [3];
  logic signed [23:0] ps [3];
  logic [1:0]         ci;
  logic               fin_load;

  // normalizer hookup
  logic        norm_start;
  comp_t       norm_vec [3];
  logic        norm_done;
  logic [63:0] norm_sq;
  unit_t       norm_unit [3];
  logic        norm_big;

  bpv_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .start    (norm_start),
    .vec_in   (norm_vec),
    .done     (norm_done),
    .sq_out   (norm_sq),
    .unit_out (norm_unit)
  );

  assign norm_big = (norm_sq > LEN_THRESH);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (state)
        S_NB_GO: norm_vec[i] = b[i];
        S_NT_GO: norm_vec[i] = t[i];
        default: norm_vec[i] = nr[i];
      endcase
    end
  end

  // basis values for u or v
  logic [15:0]        t_sel, w_sel;
  logic [47:0]        www, tww, ttw, ttt;
  logic signed [33:0] ww3, tw6, tt3;
  logic signed [33:0] b_n [4];
  logic signed [33:0] d_n [4];

  always_comb begin
    t_sel = bas_v ? v_r : u_r;
    w_sel = PARAM_ONE - t_sel;
    www = ww * w_sel;
    tww = tw * w_sel;
    ttw = tt * w_sel;
    ttt = tt * t_sel;
    ww3 = $signed({2'b0, ww}) + $signed({1'b0, ww, 1'b0});
    tt3 = $signed({2'b0, tt}) + $signed({1'b0, tt, 1'b0});
    tw6 = ($signed({2'b0, tw}) + $signed({1'b0, tw, 1'b0})) <<< 1;
    b_n[0] = $signed({1'b0, 33'(www >> 15)});
    b_n[1] = $signed({1'b0, 33'((tww + (tww << 1)) >> 15)});
    b_n[2] = $signed({1'b0, 33'((ttw + (ttw << 1)) >> 15)});
    b_n[3] = $signed({1'b0, 33'(ttt >> 15)});
    d_n[0] = 34'sd0 - ww3;
    d_n[1] = ww3 - tw6;
    d_n[2] = tw6 - tt3;
    d_n[3] = tt3;
  end

  // control point fetch and weights
  logic [CP_IDX_W-1:0] k_raw, k_sel;
  logic [1:0]          iu, jv;
  logic signed [67:0]  prod_p, prod_t, prod_b;
  logic signed [51:0]  mp [3];
  logic signed [51:0]  mt [3];
  logic signed [51:0]  mb [3];

  always_comb begin
    iu = cnt[1:0];
    jv = cnt[3:2];
    k_raw = PATCH_ROM[pi_r][cnt[3:0]];
    k_sel = (k_raw >= CP_IDX_W'(NUM_CONTROL_POINTS)) ? '0 : k_raw;
    prod_p = bu[iu] * bv[jv];
    prod_t = du[iu] * bv[jv];
    prod_b = bu[iu] * dv[jv];
    for (int c = 0; c < 3; c++) begin
      mp[c] = wp * q_r[c];
      mt[c] = wt * q_r[c];
      mb[c] = wb * q_r[c];
    end
  end

  // cross product lane and position scaling
  unit_t              xa, xb, xc, xd;
  logic signed [31:0] cross_v;
  logic signed [48:0] sprod;
  logic signed [48:0] sshift;

  always_comb begin
    case (ci)
      2'd0: begin xa = bn[1]; xb = tn[2]; xc = bn[2]; xd = tn[1]; end
      2'd1: begin xa = bn[2]; xb = tn[0]; xc = bn[0]; xd = tn[2]; end
      default: begin xa = bn[0]; xb = tn[1]; xc = bn[1]; xd = tn[0]; end
    endcase
    cross_v = (32'(xa * xb)) - (32'(xc * xd));
    sprod  = p[ci] * $signed({1'b0, scale_factor});
    sshift = (sprod + 49'sd2048) >>> 12;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid) state_next = S_BAS1;
      S_BAS1:    state_next = S_BAS2;
      S_BAS2:    state_next = bas_v ? S_ACC : S_BAS1;
      S_ACC:     if (cnt == 5'd16) state_next = S_RND;
      S_RND:     state_next = S_NB_GO;
      S_NB_GO:   state_next = S_NB_WAIT;
      S_NB_WAIT: if (norm_done) state_next = S_NT_GO;
      S_NT_GO:   state_next = S_NT_WAIT;
      S_NT_WAIT: if (norm_done) state_next = norm_big ? S_CROSS : S_NN_GO;
      S_CROSS:   if (ci == 2'd2) state_next = S_NN_GO;
      S_NN_GO:   state_next = S_NN_WAIT;
      S_NN_WAIT: if (norm_done) state_next = S_SCALE;
      S_SCALE:   if (ci == 2'd2) state_next = S_FIN;
      S_FIN:     if (!out_valid || out_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  assign in_ready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign norm_start = (state == S_NB_GO) || (state == S_NT_GO) || (state == S_NN_GO);
  assign fin_load   = (state == S_FIN) && (!out_valid || out_ready);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= SCALE_RESET;
      frame_mode   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SCALE_FACTOR: scale_factor <= cfg_data;
          REG_FRAME_MODE:   frame_mode   <= cfg_data[0];
          default: ;
        endcase
      end
      if (fin_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          pi_r  <= (patch_index >= PATCH_W'(NUM_PATCHES)) ?
                   PATCH_W'(NUM_PATCHES - 1) : patch_index;
          u_r   <= (u_param > PARAM_ONE) ? PARAM_ONE : u_param;
          v_r   <= (v_param > PARAM_ONE) ? PARAM_ONE : v_param;
          bas_v <= 1'b0;
        end
      end
      S_BAS1: begin
        ww <= w_sel * w_sel;
        tw <= t_sel * w_sel;
        tt <= t_sel * t_sel;
      end
      S_BAS2: begin
        for (int i = 0; i < 4; i++) begin
          if (bas_v) begin
            bv[i] <= b_n[i];
            dv[i] <= d_n[i];
          end else begin
            bu[i] <= b_n[i];
            du[i] <= d_n[i];
          end
        end
        bas_v   <= 1'b1;
        cnt     <= 5'd0;
        mac_vld <= 1'b0;
        for (int c = 0; c < 3; c++) begin
          ap[c] <= '0;
          at[c] <= '0;
          ab[c] <= '0;
        end
      end
      S_ACC: begin
        // weights for point cnt, accumulate point cnt-1
        wp <= prod_p[65:30];
        wt <= prod_t[65:30];
        wb <= prod_b[65:30];
        for (int c = 0; c < 3; c++) q_r[c] <= CP_ROM[k_sel][c];
        mac_vld <= (cnt != 5'd16);
        cnt     <= cnt + 5'd1;
        if (mac_vld) begin
          for (int c = 0; c < 3; c++) begin
            ap[c] <= ap[c] + 56'(mp[c]);
            at[c] <= at[c] - 56'(mt[c]);
            ab[c] <= ab[c] + 56'(mb[c]);
          end
        end
      end
      S_RND: begin
        for (int c = 0; c < 3; c++) begin
          p[c] <= comp_t'((ap[c] + (56'sd1 <<< 25)) >>> 26);
          t[c] <= comp_t'((at[c] + (56'sd1 <<< 25)) >>> 26);
          b[c] <= comp_t'((ab[c] + (56'sd1 <<< 25)) >>> 26);
        end
      end
      S_NB_WAIT: begin
        if (norm_done) begin
          for (int c = 0; c < 3; c++) begin
            if (norm_big) begin
              bn[c] <= norm_unit[c];
            end else if (((b[c] + 32'sd2) >>> 2) > 32'sd16384) begin
              bn[c] <= UNIT_Q14;
            end else if (((b[c] + 32'sd2) >>> 2) < -32'sd16384) begin
              bn[c] <= -UNIT_Q14;
            end else begin
              bn[c] <= unit_t'((b[c] + 32'sd2) >>> 2);
            end
          end
        end
      end
      S_NT_WAIT: begin
        ci <= 2'd0;
        if (norm_done) begin
          if (norm_big) begin
            for (int c = 0; c < 3; c++) tn[c] <= norm_unit[c];
          end else begin
            nr[0] <= 32'sd0;
            nr[1] <= 32'sd0;
            tn[2] <= 16'sd0;
            // short tangent: normal is straight down below z = 1, else up
            if (p[2] < 32'sd65536) begin
              nr[2] <= -32'sd16384;
              tn[0] <= 16'sd0 - bn[1];
              tn[1] <= bn[0];
            end else begin
              nr[2] <= 32'sd16384;
              tn[0] <= bn[1];
              tn[1] <= 16'sd0 - bn[0];
            end
          end
        end
      end
      S_CROSS: begin
        nr[ci] <= cross_v;
        ci     <= ci + 2'd1;
      end
      S_NN_WAIT: begin
        ci <= 2'd0;
        if (norm_done) begin
          for (int c = 0; c < 3; c++) nn[c] <= norm_unit[c];
        end
      end
      S_SCALE: begin
        if (sshift > 49'sd8388607) ps[ci] <= 24'sh7FFFFF;
        else if (sshift < -49'sd8388608) ps[ci] <= 24'sh800000;
        else ps[ci] <= sshift[23:0];
        ci <= ci + 2'd1;
      end
      default: ;
    endcase

    if (fin_load) begin
      pos_x      <= ps[0];
      pos_y      <= ps[1];
      pos_z      <= ps[2];
      normal_x   <= nn[0];
      normal_y   <= nn[1];
      normal_z   <= nn[2];
      tangent_x  <= frame_mode ? (16'sd0 - tn[0]) : tn[0];
      tangent_y  <= frame_mode ? (16'sd0 - tn[1]) : tn[1];
      tangent_z  <= frame_mode ? (16'sd0 - tn[2]) : tn[2];
      binormal_x <= bn[0];
      binormal_y <= bn[1];
      binormal_z <= bn[2];
    end
  end

endmodule

// ===== rtl/core/bpv_norm.sv =====
// vector normalizer: squared length, bit-serial square root and divider
module bpv_norm
  import bpv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  comp_t       vec_in [3],
  output logic        done,
  output logic [63:0] sq_out,
  output unit_t       unit_out [3]
);

  norm_state_t st, st_next;

  logic [31:0] mag [3];
  logic        neg [3];
  logic [63:0] sq;
  logic [63:0] rem;
  logic [63:0] root;
  logic [63:0] bitv;
  logic [46:0] num;
  logic [31:0] drem;
  logic [46:0] quo;
  logic [1:0]  idx;
  logic [5:0]  cnt;
  unit_t       unit_r [3];

  logic [63:0] sqp;
  logic [63:0] trial;
  logic [32:0] dr;
  logic        qb;
  logic [46:0] quo_fin;
  logic [15:0] qcap;
  logic [31:0] len;

  assign len   = root[31:0];
  assign sqp   = mag[idx] * mag[idx];
  assign trial = root + bitv;
  assign dr    = {drem, num[46]};
  assign qb    = (dr >= {1'b0, len});
  assign quo_fin = {quo[45:0], qb};
  assign qcap  = (quo_fin > 47'd16384) ? 16'd16384 : quo_fin[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= N_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      N_IDLE: if (start) st_next = N_SQ;
      N_SQ:   if (idx == 2'd2) st_next = N_SQRT;
      N_SQRT: if (cnt == 6'd31) st_next = N_LOAD;
      N_LOAD: begin
        if (len != 32'd0) st_next = N_DIV;
        else if (idx == 2'd2) st_next = N_DONE;
      end
      N_DIV: begin
        if (cnt == 6'd46) st_next = (idx == 2'd2) ? N_DONE : N_LOAD;
      end
      N_DONE: st_next = N_IDLE;
      default: st_next = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st)
      N_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= vec_in[i][31];
            mag[i] <= vec_in[i][31] ? (32'd0 - vec_in[i]) : vec_in[i];
          end
          sq  <= 64'd0;
          idx <= 2'd0;
        end
      end
      N_SQ: begin
        sq <= sq + sqp;
        if (idx == 2'd2) begin
          rem  <= sq + sqp;
          root <= 64'd0;
          bitv <= 64'h4000_0000_0000_0000;
          cnt  <= 6'd0;
          idx  <= 2'd0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
      N_SQRT: begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 6'd1;
      end
      N_LOAD: begin
        if (len == 32'd0) begin
          unit_r[idx] <= 16'sd0;
          idx <= idx + 2'd1;
        end else begin
          num  <= {1'b0, mag[idx], 14'd0} + {16'd0, len[31:1]};
          drem <= 32'd0;
          quo  <= 47'd0;
          cnt  <= 6'd0;
        end
      end
      N_DIV: begin
        drem <= qb ? 32'(dr - {1'b0, len}) : dr[31:0];
        num  <= {num[45:0], 1'b0};
        quo  <= quo_fin;
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd46) begin
          unit_r[idx] <= neg[idx] ? (16'sd0 - unit_t'(qcap)) : unit_t'(qcap);
          idx <= idx + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign done     = (st == N_DONE);
  assign sq_out   = sq;
  assign unit_out = unit_r;

endmodule
